/* src/rbsi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rbsi_pkg;
    localparam int unsigned NUM_AXES = 3;
endpackage
`default_nettype wire

/* src/rbsi_div_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// One restoring step per stage for the magnitude quotient.
module rbsi_div_stage #(
    parameter int unsigned NW = 49,
    parameter int unsigned DW = 33,
    parameter int unsigned LW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [DW:0]   i_rem,
    input  wire logic [LW:0]   i_quo,
    input  wire logic          i_sat,
    input  wire logic [LW:0]   i_lim,
    output logic      [NW-1:0] o_num,
    output logic      [DW-1:0] o_den,
    output logic      [DW:0]   o_rem,
    output logic      [LW:0]   o_quo,
    output logic               o_sat,
    output logic      [LW:0]   o_lim
);
    logic [DW+1:0] w_r;
    logic [DW:0]   n_rem;
    logic [LW:0]   n_quo;
    logic          n_sat;
    logic [LW+1:0] w_q;
    always_comb begin
        w_r   = {i_rem, i_num[NW-1]};
        w_q   = {i_quo, 1'b0};
        n_rem = w_r[DW:0];
        if (w_r >= {1'b0, 1'b0, i_den}) begin
            n_rem = (DW+1)'(w_r - {2'b00, i_den});
            w_q[0] = 1'b1;
        end
        n_sat = i_sat;
        n_quo = w_q[LW:0];
        if (i_sat || w_q > {1'b0, i_lim}) begin
            n_sat = 1'b1;
            n_quo = i_lim;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num <= {i_num[NW-2:0], 1'b0};
            o_den <= i_den;
            o_rem <= n_rem;
            o_quo <= n_quo;
            o_sat <= n_sat;
            o_lim <= i_lim;
        end
    end
endmodule
`default_nettype wire

/* src/rbsi_axis.sv */
`timescale 1ns / 1ps
`default_nettype none
// Per-axis slab: plane distances, two pipelined dividers, ordered entry/exit.
module rbsi_axis #(
    parameter int unsigned CW = 32,
    parameter int unsigned FB = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [CW-1:0] i_o,
    input  wire logic signed [CW-1:0] i_d,
    input  wire logic signed [CW-1:0] i_lo,
    input  wire logic signed [CW-1:0] i_hi,
    output logic signed      [CW-1:0] o_entry,
    output logic signed      [CW-1:0] o_exit
);
    localparam int unsigned NW = CW + 1 + FB;
    localparam int unsigned DW = CW + 1;
    localparam int unsigned NS = NW;
    localparam logic [CW:0] HALF = {2'b01, {(CW-1){1'b0}}};

    // stage 0: distances
    logic signed [CW:0] r_p, r_q, r_d;
    logic               r_dz, r_in;
    logic signed [CW:0] w_p, w_q;
    assign w_p = $signed({i_lo[CW-1], i_lo}) - $signed({i_o[CW-1], i_o});
    assign w_q = $signed({i_hi[CW-1], i_hi}) - $signed({i_o[CW-1], i_o});
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= w_p;
            r_q  <= w_q;
            r_d  <= {i_d[CW-1], i_d};
            r_dz <= (i_d == '0);
            r_in <= ((w_p <= 0) && (w_q >= 0)) || ((w_p >= 0) && (w_q <= 0));
        end
    end

    logic [NW-1:0] w_na [2];
    logic [CW:0]   w_lim [2];
    logic          w_neg [2];
    logic [DW-1:0] w_ud;
    assign w_ud = r_d[CW] ? DW'(-r_d) : DW'(r_d);
    assign w_neg[0] = r_p[CW] != r_d[CW] && r_p != '0;
    assign w_neg[1] = r_q[CW] != r_d[CW] && r_q != '0;
    assign w_na[0] = {(r_p[CW] ? DW'(-r_p) : DW'(r_p)), {FB{1'b0}}};
    assign w_na[1] = {(r_q[CW] ? DW'(-r_q) : DW'(r_q)), {FB{1'b0}}};
    assign w_lim[0] = w_neg[0] ? HALF : HALF - 1'b1;
    assign w_lim[1] = w_neg[1] ? HALF : HALF - 1'b1;

    logic [NW-1:0] s_num [2][NS+1];
    logic [DW-1:0] s_den [2][NS+1];
    logic [DW:0]   s_rem [2][NS+1];
    logic [CW:0]   s_quo [2][NS+1];
    logic          s_sat [2][NS+1];
    logic [CW:0]   s_lim [2][NS+1];
    // side flags, bit s lines up with divider stage s
    logic [NS:1]   s_dz, s_in, s_ng0, s_ng1;

    for (genvar g = 0; g < 2; g++) begin : g_div
        assign s_num[g][0] = w_na[g];
        assign s_den[g][0] = w_ud;
        assign s_rem[g][0] = '0;
        assign s_quo[g][0] = '0;
        assign s_sat[g][0] = 1'b0;
        assign s_lim[g][0] = w_lim[g];
        for (genvar s = 0; s < NS; s++) begin : g_st
            rbsi_div_stage #(.NW(NW), .DW(DW), .LW(CW)) u_st (
                .i_clk(i_clk), .i_en(i_en),
                .i_num(s_num[g][s]), .i_den(s_den[g][s]), .i_rem(s_rem[g][s]),
                .i_quo(s_quo[g][s]), .i_sat(s_sat[g][s]), .i_lim(s_lim[g][s]),
                .o_num(s_num[g][s+1]), .o_den(s_den[g][s+1]), .o_rem(s_rem[g][s+1]),
                .o_quo(s_quo[g][s+1]), .o_sat(s_sat[g][s+1]), .o_lim(s_lim[g][s+1])
            );
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            s_dz  <= {s_dz[NS-1:1], r_dz};
            s_in  <= {s_in[NS-1:1], r_in};
            s_ng0 <= {s_ng0[NS-1:1], w_neg[0]};
            s_ng1 <= {s_ng1[NS-1:1], w_neg[1]};
        end
    end

    // final: sign, order, zero-direction override
    logic signed [CW-1:0] w_a, w_b;
    localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};
    assign w_a = s_ng0[NS] ? CW'(-s_quo[0][NS]) : CW'(s_quo[0][NS]);
    assign w_b = s_ng1[NS] ? CW'(-s_quo[1][NS]) : CW'(s_quo[1][NS]);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (s_dz[NS]) begin
                o_entry <= s_in[NS] ? SMIN : SMAX;
                o_exit  <= s_in[NS] ? SMAX : SMIN;
            end else if (w_a < w_b) begin
                o_entry <= w_a;
                o_exit  <= w_b;
            end else begin
                o_entry <= w_b;
                o_exit  <= w_a;
            end
        end
    end
endmodule
`default_nettype wire

/* src/ray_box_slab_intersect_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one ray-box test per cycle; each divider bit is its own pipeline stage.
// A stall at the output freezes the whole pipeline; the output register holds the result.
// Reset (synchronous, active low) clears only the valid bits; data registers are not reset.
module ray_box_slab_intersect_unit #(
    parameter int unsigned COORD_WIDTH = 32,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // origin x,y,z, dir x,y,z, box_min x,y,z, box_max x,y,z from bit 0 up
    input  wire logic [12*COORD_WIDTH-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // distance from bit 0 up
    output logic [((COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // hit
    output logic                          m_axis_tuser
);
    import rbsi_pkg::*;
    localparam int unsigned CW  = COORD_WIDTH;
    localparam int unsigned LAT = CW + FRAC_BITS + 4;

    // whole pipe advances when the output register is free or being drained
    logic w_en;
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    logic signed [CW-1:0] w_en_ax [NUM_AXES];
    logic signed [CW-1:0] w_ex_ax [NUM_AXES];
    for (genvar k = 0; k < NUM_AXES; k++) begin : g_ax
        rbsi_axis #(.CW(CW), .FB(FRAC_BITS)) u_axis (
            .i_clk(i_clk), .i_en(w_en),
            .i_o (s_axis_tdata[k*CW +: CW]),
            .i_d (s_axis_tdata[(3+k)*CW +: CW]),
            .i_lo(s_axis_tdata[(6+k)*CW +: CW]),
            .i_hi(s_axis_tdata[(9+k)*CW +: CW]),
            .o_entry(w_en_ax[k]), .o_exit(w_ex_ax[k])
        );
    end

    // reduce across axes; axis 0 seeds the running entry/exit
    logic signed [CW-1:0] r_tmin, r_tmax;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tmin <= w_en_ax[0];
            r_tmax <= w_ex_ax[0];
        end
    end
    // axes 1 and 2 must line up with the registered axis 0: register them too
    logic signed [CW-1:0] r_e1, r_x1, r_e2, r_x2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1 <= w_en_ax[1]; r_x1 <= w_ex_ax[1];
            r_e2 <= w_en_ax[2]; r_x2 <= w_ex_ax[2];
        end
    end
    logic signed [CW-1:0] w_mn, w_mx;
    always_comb begin
        w_mn = (r_e1 > r_tmin) ? r_e1 : r_tmin;
        w_mx = (r_x1 < r_tmax) ? r_x1 : r_tmax;
        if (r_e2 > w_mn) w_mn = r_e2;
        if (r_x2 < w_mx) w_mx = r_x2;
    end

    logic n_hit;
    assign n_hit = !(w_mx < 0 || w_mn > w_mx);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (w_en) begin
            m_axis_tvalid <= r_vld[LAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_axis_tuser <= n_hit;
            m_axis_tdata <= $bits(m_axis_tdata)'($unsigned(n_hit ? w_mn : w_mx));
        end
    end
endmodule
`default_nettype wire

/* src/rbsi_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module rbsi_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic m_axis_tuser
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
        else $error("result dropped under stall");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while output empty");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule
bind ray_box_slab_intersect_unit rbsi_checker u_chk (.*);
`default_nettype wire

/* tb/tb_ray_box_slab_intersect_unit.sv */
`timescale 1ns / 1ps
module tb_ray_box_slab_intersect_unit;
    import rbsi_pkg::*;

    localparam int CW       = 32;
    localparam int FB       = 16;
    localparam int LATENCY  = CW + FB + 4;
    localparam int N_RANDOM = 450;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
    } slab_result_t;

    // one ray/box pair: [0..2] origin, [3..5] dir, [6..8] box min, [9..11] box max
    typedef logic [31:0] ray_box_t [12];

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // origin x,y,z, dir x,y,z, box_min x,y,z, box_max x,y,z from bit 0 up
    logic [12*CW-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // distance from bit 0 up
    logic [31:0] m_axis_tdata;
    // hit
    logic m_axis_tuser;

    ray_box_slab_intersect_unit #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    slab_result_t expected_hits[$];
    int  n_mismatch = 0;
    int  n_unexpected = 0;
    bit  stim_done = 0;
    // idling knobs
    bit  quiet_mode = 0;      // no random idling on either side
    bit  hold_off = 0;        // sink holds tready low for a long stretch
    int  hold_cycles = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Exact (n << FB) / d, truncated toward zero, saturated to 32 bits.
    function automatic longint ray_param(longint n, longint d);
        logic signed [127:0] num, den, quo;
        num = 128'(n) <<< FB;
        den = 128'(d);
        quo = num / den;          // SV signed division truncates toward zero
        if (quo > SMAX) return SMAX;
        if (quo < SMIN) return SMIN;
        return longint'(quo);
    endfunction

    function automatic slab_result_t predict_slab_hit(ray_box_t rb);
        longint t_enter, t_exit, o, d, p, q, a, b, ax_en, ax_ex;
        slab_result_t r;
        t_enter = SMIN;
        t_exit  = SMAX;
        for (int k = 0; k < NUM_AXES; k++) begin
            o = longint'(signed'(rb[k]));
            d = longint'(signed'(rb[3+k]));
            p = longint'(signed'(rb[6+k])) - o;
            q = longint'(signed'(rb[9+k])) - o;
            if (d == 0) begin
                // parallel ray: free axis if origin sits within the slab, else a miss
                if ((p <= 0 && q >= 0) || (p >= 0 && q <= 0)) begin
                    ax_en = SMIN; ax_ex = SMAX;
                end else begin
                    ax_en = SMAX; ax_ex = SMIN;
                end
            end else begin
                a = ray_param(p, d);
                b = ray_param(q, d);
                ax_en = (a < b) ? a : b;
                ax_ex = (a < b) ? b : a;
            end
            if (ax_en > t_enter) t_enter = ax_en;
            if (ax_ex < t_exit)  t_exit  = ax_ex;
        end
        if (t_exit < 0 || t_enter > t_exit) begin
            r.hit = 1'b0; r.distance = t_exit[31:0];
        end else begin
            r.hit = 1'b1; r.distance = t_enter[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3, 4: return 32'($signed($urandom_range(0, 40)) - 20) <<< FB;
            5, 6: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    // Random scene: box around a random centre, origin near zero, random direction.
    function automatic ray_box_t rand_scene();
        ray_box_t rb;
        int c, h;
        for (int k = 0; k < 3; k++) begin
            c = $signed($urandom_range(0, 200)) - 100;
            h = $urandom_range(1, 20);
            rb[k]   = 32'($signed($urandom_range(0, 60)) - 30) <<< FB;
            rb[3+k] = ($urandom_range(0, 9) == 0) ? 32'h0
                      : 32'($signed($urandom_range(0, 131072)) - 65536);
            rb[6+k] = 32'(c - h) <<< FB;
            rb[9+k] = 32'(c + h) <<< FB;
            if ($urandom_range(0, 7) == 0) begin
                // swapped corners
                rb[6+k] = 32'(c + h) <<< FB;
                rb[9+k] = 32'(c - h) <<< FB;
            end
        end
        return rb;
    endfunction

    task automatic send_ray_box(ray_box_t rb);
        logic [12*CW-1:0] flat;
        // random gap before offering, with idling off in quiet mode
        while (!quiet_mode && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        for (int k = 0; k < 12; k++) flat[32*k +: 32] = rb[k];
        s_axis_tdata  <= flat;
        s_axis_tvalid <= 1'b1;
        // transfer happens on the rising edge where tready is seen high
        do @(posedge i_clk); while (!s_axis_tready);
        expected_hits.push_back(predict_slab_hit(rb));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(negedge i_clk);
    endtask

    function automatic ray_box_t mk(logic [31:0] o, logic [31:0] d,
                                    logic [31:0] lo, logic [31:0] hi);
        ray_box_t rb;
        for (int k = 0; k < 3; k++) begin
            rb[k] = o; rb[3+k] = d; rb[6+k] = lo; rb[9+k] = hi;
        end
        return rb;
    endfunction

    // directed table: check_fixed marks rows whose result is obvious by inspection
    typedef struct {
        ray_box_t     rb;
        bit           check_fixed;
        slab_result_t fixed;
    } directed_row_t;

    directed_row_t dir_rows[$];

    task automatic build_directed();
        directed_row_t row;
        ray_box_t rb;
        localparam logic [31:0] ONE = 32'h0001_0000;
        // parallel ray, origin between planes on all axes: free axes, hit at SMIN
        row.rb = mk(32'h0, 32'h0, -ONE, ONE); row.check_fixed = 1;
        row.fixed = '{1'b1, 32'h8000_0000}; dir_rows.push_back(row);
        // parallel ray, origin on a plane boundary: still inside
        row.rb = mk(ONE, 32'h0, -ONE, ONE); row.check_fixed = 1;
        row.fixed = '{1'b1, 32'h8000_0000}; dir_rows.push_back(row);
        // parallel ray outside the slab: miss at SMIN
        row.rb = mk(32'h0, 32'h0, ONE, 32'h0002_0000); row.check_fixed = 1;
        row.fixed = '{1'b0, 32'h8000_0000}; dir_rows.push_back(row);
        // unit ray toward box at [1,2]: hit, entry 1.0
        row.rb = mk(32'h0, ONE, ONE, 32'h0002_0000); row.check_fixed = 1;
        row.fixed = '{1'b1, ONE}; dir_rows.push_back(row);
        // box behind: miss carrying exit -1.0
        row.rb = mk(32'h0, ONE, 32'hfffe_0000, -ONE); row.check_fixed = 1;
        row.fixed = '{1'b0, -ONE}; dir_rows.push_back(row);
        // origin inside: hit with entry -1.0
        row.rb = mk(32'h0, ONE, -ONE, ONE); row.check_fixed = 1;
        row.fixed = '{1'b1, -ONE}; dir_rows.push_back(row);
        row.check_fixed = 0;
        // inverted box
        row.rb = mk(32'h0, ONE, 32'h0002_0000, ONE); dir_rows.push_back(row);
        // negative direction
        row.rb = mk(32'h0, -ONE, 32'hfffe_0000, -ONE); dir_rows.push_back(row);
        // overflow: huge span over tiny direction
        row.rb = mk(32'h8000_0000, 32'h1, 32'h8000_0000, 32'h7fff_ffff); dir_rows.push_back(row);
        row.rb = mk(32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        dir_rows.push_back(row);
        row.rb = mk(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        dir_rows.push_back(row);
        row.rb = mk(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        dir_rows.push_back(row);
        row.rb = mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        dir_rows.push_back(row);
        row.rb = mk(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555);
        dir_rows.push_back(row);
        // mixed axes: one parallel-outside, others hitting
        rb = mk(32'h0, ONE, ONE, 32'h0002_0000); rb[4] = 32'h0; rb[7] = 32'h0003_0000;
        row.rb = rb; dir_rows.push_back(row);
        // tangent: entry equals exit
        row.rb = mk(32'h0, ONE, ONE, ONE); dir_rows.push_back(row);
    endtask

    // stimulus
    initial begin
        ray_box_t rb;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        i_rst_n       = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        build_directed();
        foreach (dir_rows[i]) begin
            send_ray_box(dir_rows[i].rb);
            if (dir_rows[i].check_fixed)
                expected_hits[$] = dir_rows[i].fixed;
        end
        // sender pauses until everything is back
        wait_drained();
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 100) quiet_mode = 1;
            if (i == 180) quiet_mode = 0;
            if (i == 250) begin
                hold_cycles = 3 * LATENCY;
                hold_off = 1;   // sink stalls; input must back up
            end
            if (i == 320) wait_drained();
            if ($urandom_range(0, 3) == 0)
                for (int k = 0; k < 12; k++) rb[k] = rand_coord();
            else
                rb = rand_scene();
            send_ray_box(rb);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    // sink: random tready, long hold-off counted here
    initial begin
        m_axis_tready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                if (hold_cycles == 0) hold_off = 0;
                else hold_cycles--;
            end else begin
                m_axis_tready <= quiet_mode || ($urandom_range(0, 99) >= 7);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        slab_result_t exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_hits.size() == 0) begin
                n_unexpected++;
                if (n_mismatch + n_unexpected <= 10)
                    $display("unexpected result hit=%0b distance=%h",
                             m_axis_tuser, m_axis_tdata);
            end else begin
                exp_r = expected_hits.pop_front();
                if (exp_r.hit !== m_axis_tuser || exp_r.distance !== m_axis_tdata) begin
                    n_mismatch++;
                    if (n_mismatch + n_unexpected <= 10)
                        $display("mismatch: exp hit=%0b distance=%h, got hit=%0b distance=%h",
                                 exp_r.hit, exp_r.distance, m_axis_tuser, m_axis_tdata);
                end
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_mismatch == 0 && n_unexpected == 0 && expected_hits.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
